// File: rtl/core/cdq_pkg.sv
// package for the circular deque core: widths, operation and status codes
package cdq_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// File: rtl/core/cdq_ring.sv
// ring store of the deque: one write port, one registered read port
module cdq_ring #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic [cdq_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [cdq_pkg::DATA_W-1:0] rd_data
);

  logic [cdq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [cdq_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/circular_deque_core.sv
// top level of the circular deque: index and count control around the ring store
//
//   channel  direction  handshake           payload
//   in       input      start / busy        in_kind, in_value
//   out      output     out_valid strobe    out_data, out_status, out_occupancy
//
// one operation is taken per cycle; busy stays low
// the result appears in the cycle after the transfer, for one cycle
// a pop reads the ring store at the transfer edge; its registered read port sets the latency
// a push writes at the transfer edge, so a following pop sees the word
// synchronous active-low reset empties the deque; the ring store is not cleared
// the receiver cannot stall, so no result is ever held back
module circular_deque_core #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [cdq_pkg::KIND_W-1:0]    in_kind,
  input  logic signed [cdq_pkg::DATA_W-1:0] in_value,
  output logic                          out_valid,
  output logic signed [cdq_pkg::DATA_W-1:0] out_data,
  output logic [cdq_pkg::STATUS_W-1:0]  out_status,
  output logic [cdq_pkg::OCC_W-1:0]     out_occupancy
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] rear_r, rear_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic             out_pop_r, out_pop_nxt;
  cdq_pkg::status_t out_status_r, out_status_nxt;
  logic [cdq_pkg::OCC_W-1:0] out_occ_r;

  logic             accept;
  logic             is_push;
  logic             full;
  logic             empty;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] front_prev;
  logic [IDX_W-1:0] front_next;
  logic [IDX_W-1:0] rear_prev;
  logic [IDX_W-1:0] rear_next;
  logic [cdq_pkg::DATA_W-1:0] rd_data;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_push = (in_kind == cdq_pkg::KIND_PUSH_FRONT) || (in_kind == cdq_pkg::KIND_PUSH_REAR);
  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);

  assign front_prev = (front_r == '0) ? IDX_LAST : front_r - IDX_W'(1);
  assign front_next = (front_r == IDX_LAST) ? '0 : front_r + IDX_W'(1);
  assign rear_prev  = (rear_r == '0) ? IDX_LAST : rear_r - IDX_W'(1);
  assign rear_next  = (rear_r == IDX_LAST) ? '0 : rear_r + IDX_W'(1);

  always_comb begin
    front_nxt      = front_r;
    rear_nxt       = rear_r;
    count_nxt      = count_r;
    out_pop_nxt    = 1'b0;
    out_status_nxt = cdq_pkg::ST_DONE;
    wr_en          = 1'b0;
    wr_addr        = '0;
    rd_en          = 1'b0;
    rd_addr        = front_r;
    if (accept) begin
      if (is_push) begin
        if (full) begin
          out_status_nxt = cdq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_ONE;
          if (empty) begin
            front_nxt = '0;
            rear_nxt  = '0;
            wr_addr   = '0;
          end else if (in_kind == cdq_pkg::KIND_PUSH_FRONT) begin
            front_nxt = front_prev;
            wr_addr   = front_prev;
          end else begin
            rear_nxt = rear_next;
            wr_addr  = rear_next;
          end
        end
      end else begin
        if (empty) begin
          out_status_nxt = cdq_pkg::ST_EMPTY;
        end else begin
          rd_en       = 1'b1;
          out_pop_nxt = 1'b1;
          count_nxt   = count_r - CNT_ONE;
          if (in_kind == cdq_pkg::KIND_POP_FRONT) begin
            rd_addr   = front_r;
            front_nxt = front_next;
          end else begin
            rd_addr  = rear_r;
            rear_nxt = rear_prev;
          end
          if (count_r == CNT_ONE) begin
            front_nxt = '0;
            rear_nxt  = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r      <= '0;
      rear_r       <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      out_pop_r    <= 1'b0;
      out_status_r <= cdq_pkg::ST_DONE;
    end else begin
      front_r      <= front_nxt;
      rear_r       <= rear_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= accept;
      out_pop_r    <= out_pop_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_occ_r <= cdq_pkg::OCC_W'(count_nxt);
  end

  cdq_ring #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_valid     = out_valid_r;
  assign out_data      = out_pop_r ? rd_data : '0;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

  a_result_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept))
    else $error("result without a transfer");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above depth");

  a_empty_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == cdq_pkg::ST_EMPTY) |-> (out_occupancy == '0 && out_data == '0))
    else $error("empty refusal with nonzero occupancy or data");

  a_indices_home_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (front_r == '0 && rear_r == '0))
    else $error("indices not reset on empty deque");

endmodule

// File: tb/sv/tb_circular_deque_core.sv
// self-checking testbench for circular_deque_core: random push/pop traffic against a deque predictor
`timescale 1ns / 100ps

module tb_circular_deque_core;
  import cdq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int RANDOM_ITEMS = 1350;

  typedef struct {
    kind_t                     kind;
    logic signed [DATA_W-1:0]  value;
  } deque_op_t;

  typedef struct {
    logic signed [DATA_W-1:0]  data;
    status_t                   status;
    logic [OCC_W-1:0]          occupancy;
  } deque_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [KIND_W-1:0]           in_kind = '0;
  logic signed [DATA_W-1:0]    in_value = '0;
  logic                        out_valid;
  logic signed [DATA_W-1:0]    out_data;
  logic [STATUS_W-1:0]         out_status;
  logic [OCC_W-1:0]            out_occupancy;

  deque_op_t                   op_q[$];
  deque_result_t               expected_q[$];
  int                          mismatches = 0;

  logic [DATA_W-1:0]           ring_copy[DEPTH];
  logic [IDX_W-1:0]            front_copy = '0;
  logic [IDX_W-1:0]            rear_copy = '0;
  int                          count_copy = 0;

  int                          gen_count = 0;
  int                          gap_left = 0;
  bit                          quiet = 1'b0;

  circular_deque_core #(.DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic apply_deque_op(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] word);
    deque_result_t res;
    res.data = '0;
    res.status = ST_DONE;
    if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_REAR) begin
      if (count_copy >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        if (count_copy == 0) begin
          front_copy = '0;
          rear_copy = '0;
          ring_copy[0] = word;
        end else if (kind == KIND_PUSH_FRONT) begin
          front_copy = front_copy - IDX_W'(1);
          ring_copy[front_copy] = word;
        end else begin
          rear_copy = rear_copy + IDX_W'(1);
          ring_copy[rear_copy] = word;
        end
        count_copy++;
      end
    end else begin
      if (count_copy == 0) begin
        res.status = ST_EMPTY;
      end else begin
        if (kind == KIND_POP_FRONT) begin
          res.data = ring_copy[front_copy];
          front_copy = front_copy + IDX_W'(1);
        end else begin
          res.data = ring_copy[rear_copy];
          rear_copy = rear_copy - IDX_W'(1);
        end
        count_copy--;
        if (count_copy == 0) begin
          front_copy = '0;
          rear_copy = '0;
        end
      end
    end
    res.occupancy = count_copy[OCC_W-1:0];
    expected_q.push_back(res);
  endtask

  task automatic add_op(input kind_t kind, input logic signed [DATA_W-1:0] value);
    deque_op_t op;
    op.kind = kind;
    op.value = value;
    op_q.push_back(op);
    if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_REAR) begin
      if (gen_count < DEPTH) gen_count++;
    end else if (gen_count > 0) begin
      gen_count--;
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'sh7fff_ffff;
    if (r < 6) return 32'sh8000_0000;
    if (r < 8) return '0;
    if (r < 10) return -32'sd1;
    return $urandom;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    logic                     next_start;
    logic [KIND_W-1:0]        next_kind;
    logic signed [DATA_W-1:0] next_value;
    deque_op_t                op;
    next_start = start;
    next_kind = in_kind;
    next_value = in_value;
    if (!rst_n) begin
      next_start = 1'b0;
    end else if (!(start && busy)) begin
      if (start) apply_deque_op(in_kind, in_value);
      if ($urandom_range(0, 99) < 2) quiet = ~quiet;
      if (gap_left > 0) begin
        gap_left--;
        next_start = 1'b0;
      end else if (op_q.size() > 0) begin
        op = op_q.pop_front();
        next_start = 1'b1;
        next_kind = op.kind;
        next_value = op.value;
        gap_left = quiet ? 0 : pick_gap();
      end else begin
        next_start = 1'b0;
      end
    end
    start <= next_start;
    in_kind <= next_kind;
    in_value <= next_value;
  end

  always @(posedge clk) begin
    deque_result_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: data %0d status %0d occupancy %0d",
               out_data, out_status, out_occupancy);
        mismatches++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_data !== exp_res.data) begin
          $error("data: expected %0d, actual %0d", exp_res.data, out_data);
          mismatches++;
        end
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_status);
          mismatches++;
        end
        if (out_occupancy !== exp_res.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", exp_res.occupancy, out_occupancy);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int mode;
    int phase_len;
    int push_pct;
    int total;
    kind_t kind;

    // empty pops, extremes, pushes into empty from both ends, last pop
    add_op(KIND_POP_FRONT, 32'sh1234_5678);
    add_op(KIND_POP_REAR, -32'sd1);
    add_op(KIND_PUSH_FRONT, 32'sh7fff_ffff);
    add_op(KIND_PUSH_REAR, 32'sh8000_0000);
    add_op(KIND_PUSH_FRONT, '0);
    add_op(KIND_PUSH_REAR, -32'sd1);
    add_op(KIND_POP_FRONT, '0);
    add_op(KIND_POP_REAR, '0);
    add_op(KIND_POP_FRONT, -32'sd1);
    add_op(KIND_POP_REAR, '0);
    add_op(KIND_POP_REAR, '0);
    add_op(KIND_PUSH_REAR, 32'sd1);
    add_op(KIND_POP_FRONT, '0);
    add_op(KIND_PUSH_FRONT, 32'sh5a5a_a5a5);
    add_op(KIND_PUSH_FRONT, 32'sh0f0f_f0f0);
    add_op(KIND_POP_REAR, '0);
    add_op(KIND_POP_REAR, '0);
    add_op(KIND_POP_FRONT, '0);
    add_op(KIND_PUSH_REAR, 32'sh8000_0001);
    add_op(KIND_POP_REAR, '0);

    // fill past full, drain past empty, then mixed phases
    total = 0;
    mode = 0;
    while (total < RANDOM_ITEMS) begin
      if (total == 0 || total == 200) begin
        phase_len = 200;
      end else begin
        mode = $urandom_range(0, 2);
        phase_len = $urandom_range(30, 200);
      end
      case (mode)
        0: push_pct = 88;
        1: push_pct = 12;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < phase_len && total < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          kind = kind_t'($urandom_range(0, 1));
        end else begin
          kind = kind_t'(2 + $urandom_range(0, 1));
        end
        add_op(kind, pick_value());
        total++;
      end
      if (total == 200) mode = 1;
      if (mode == 0 && gen_count >= DEPTH) mode = 1;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (op_q.size() > 0 || start) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/cdq_pkg.sv
rtl/core/cdq_ring.sv
rtl/core/circular_deque_core.sv
tb/sv/tb_circular_deque_core.sv
